>>> hw/rtl/gsd_pkg.sv
package gsd_pkg;

    // Widths of the result value and of the divisor register
    localparam int VALUE_WIDTH   = 32;
    localparam int DIVISOR_WIDTH = 16;

    // Unary count saturates at the top of this width
    localparam int QUOT_WIDTH = 32;

    // Derived widths
    localparam int BITS_WIDTH = $clog2(DIVISOR_WIDTH + 1);         // b = 0 .. DIVISOR_WIDTH
    localparam int CNT_WIDTH  = $clog2(DIVISOR_WIDTH);             // bits read 0 .. DW-1
    localparam int ACC_WIDTH  = DIVISOR_WIDTH - 1;                 // first remainder part
    localparam int REM_WIDTH  = DIVISOR_WIDTH + 1;                 // signed remainder
    localparam int PROD_WIDTH = QUOT_WIDTH + DIVISOR_WIDTH;
    localparam int SUM_WIDTH  = PROD_WIDTH + 2;

    localparam logic [DIVISOR_WIDTH-1:0] DIVISOR_RESET = DIVISOR_WIDTH'(4);

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_TRUNC = 2'd1,
        STATUS_OVF   = 2'd2
    } status_t;

    // Codeword decode phase
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_UNARY = 4'b0010,
        PH_REM   = 4'b0100,
        PH_EXTRA = 4'b1000
    } phase_t;

endpackage

>>> hw/rtl/golomb_signed_decoder.sv
// Golomb decoder with zigzag unmapping. Feed the coded stream one bit per transfer
// (kind 0) and mark the end of a stream with kind 1. Each codeword is a run of
// unary ones closed by a zero, then a truncated-binary remainder of b-1 or b bits,
// where b = ceil(log2 m) and m is the divisor register (0 acts as 1, and m = 1
// reads no remainder). The decoder forms q*m + r and unmaps it to a signed value;
// an end marker inside a codeword yields value 0 with status 1, and a quotient
// past 2^32-1 or a mapped value past 2^32-1 saturates with status 2. The block
// takes one transfer every clock; the result of a codeword is presented through a
// three-register emit pipeline (capture, 32x16 multiply, add and unmap) whose first
// register loads at the transfer that completes it. The input stalls only while
// that pipeline is full behind a stalled output. Write the divisor between
// codewords; b and the truncation threshold 2^b - m are worked out at the write
// and registered with the divisor.
module golomb_signed_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    // divisor register
    input  logic                                divisor_write,
    input  logic [gsd_pkg::DIVISOR_WIDTH-1:0]   divisor,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic                                code_bit,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [gsd_pkg::VALUE_WIDTH-1:0] value,
    output logic [1:0]                          status
);

    localparam int DW  = gsd_pkg::DIVISOR_WIDTH;
    localparam int VW  = gsd_pkg::VALUE_WIDTH;
    localparam int QW  = gsd_pkg::QUOT_WIDTH;
    localparam int BW  = gsd_pkg::BITS_WIDTH;
    localparam int CW  = gsd_pkg::CNT_WIDTH;
    localparam int AW  = gsd_pkg::ACC_WIDTH;
    localparam int RW  = gsd_pkg::REM_WIDTH;
    localparam int PW  = gsd_pkg::PROD_WIDTH;
    localparam int SW  = gsd_pkg::SUM_WIDTH;

    // Derive b from m: the bit length of m-1 (m is never zero here)
    function automatic logic [BW-1:0] bits_for(input logic [DW-1:0] m);
        logic [DW-1:0] mm1;
        logic [BW-1:0] b;
        begin
            mm1 = m - DW'(1);
            b   = '0;
            for (int i = 0; i < DW; i++)
            begin
                if (mm1[i])
                begin
                    b = BW'(i + 1);
                end
            end
            return b;
        end
    endfunction

    // ------------------------------------------------------------------
    // Divisor register and its derived values
    // ------------------------------------------------------------------
    logic [DW-1:0] m_reg, m_next;
    logic [BW-1:0] b_reg, b_next;
    logic [DW-1:0] t_reg, t_next;

    logic [DW:0]   pow_b;

    always_comb
    begin
        m_next = (divisor == '0) ? DW'(1) : divisor;
        b_next = bits_for(m_next);
        pow_b  = (DW + 1)'(1) << b_next;
        t_next = DW'(pow_b - {1'b0, m_next});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg <= gsd_pkg::DIVISOR_RESET;
            b_reg <= bits_for(gsd_pkg::DIVISOR_RESET);
            t_reg <= DW'(((DW + 1)'(1) << bits_for(gsd_pkg::DIVISOR_RESET))
                         - {1'b0, gsd_pkg::DIVISOR_RESET});
        end
        else if (divisor_write)
        begin
            m_reg <= m_next;
            b_reg <= b_next;
            t_reg <= t_next;
        end
    end

    // ------------------------------------------------------------------
    // Emit pipeline handshake: each stage fills whenever its slot drains
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic out_free, s2_ready, s1_ready, accept;

    assign out_free = !out_valid_reg || !out_stall;
    assign s2_ready = !s2_valid_reg || out_free;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;
    assign accept   = in_valid && s1_ready;

    // ------------------------------------------------------------------
    // Codeword state
    // ------------------------------------------------------------------
    gsd_pkg::phase_t phase_reg, phase_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [AW-1:0]   acc_reg, acc_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;

    logic            emit, emit_trunc;
    logic [RW-1:0]   emit_r;
    logic            chk_en;
    logic [AW-1:0]   chk_acc;
    logic [CW-1:0]   chk_cnt;
    logic [BW-1:0]   chk_cnt_p1;

    always_comb
    begin
        phase_next = phase_reg;
        q_next     = q_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        emit       = 1'b0;
        emit_trunc = 1'b0;
        emit_r     = '0;
        chk_en     = 1'b0;
        chk_acc    = '0;
        chk_cnt    = '0;
        chk_cnt_p1 = '0;

        if (accept)
        begin
            if (kind)
            begin
                // end marker: report a cut-off codeword, drop the partial state
                if (phase_reg != gsd_pkg::PH_IDLE)
                begin
                    emit       = 1'b1;
                    emit_trunc = 1'b1;
                    phase_next = gsd_pkg::PH_IDLE;
                    q_next     = '0;
                    acc_next   = '0;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                end
            end
            else
            begin
                case (phase_reg)
                    gsd_pkg::PH_IDLE, gsd_pkg::PH_UNARY:
                    begin
                        if (code_bit)
                        begin
                            // count the unary run, hold at the top and flag it
                            if (q_reg == '1)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                q_next = q_reg + QW'(1);
                            end
                            phase_next = gsd_pkg::PH_UNARY;
                        end
                        else if (b_reg == '0)
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            chk_en  = 1'b1;
                            chk_acc = '0;
                            chk_cnt = '0;
                        end
                    end
                    gsd_pkg::PH_REM:
                    begin
                        chk_en  = 1'b1;
                        chk_acc = {acc_reg[AW-2:0], code_bit};
                        chk_cnt = cnt_reg + CW'(1);
                    end
                    gsd_pkg::PH_EXTRA:
                    begin
                        emit   = 1'b1;
                        emit_r = {1'b0, acc_reg, code_bit} - {1'b0, t_reg};
                    end
                    default:
                    begin
                        phase_next = gsd_pkg::PH_IDLE;
                    end
                endcase

                // first remainder part complete? then finish or ask for one more bit
                if (chk_en)
                begin
                    chk_cnt_p1 = BW'(chk_cnt) + BW'(1);
                    acc_next   = chk_acc;
                    cnt_next   = chk_cnt;
                    if (chk_cnt_p1 < b_reg)
                    begin
                        phase_next = gsd_pkg::PH_REM;
                    end
                    else if ({1'b0, chk_acc} < t_reg)
                    begin
                        emit   = 1'b1;
                        emit_r = RW'(chk_acc);
                    end
                    else
                    begin
                        phase_next = gsd_pkg::PH_EXTRA;
                    end
                end

                if (emit)
                begin
                    phase_next = gsd_pkg::PH_IDLE;
                    q_next     = '0;
                    acc_next   = '0;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= gsd_pkg::PH_IDLE;
            q_reg     <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            q_reg     <= q_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the finished codeword
    // ------------------------------------------------------------------
    logic            s1_trunc_reg, s1_ovf_reg;
    logic [QW-1:0]   s1_q_reg;
    logic [DW-1:0]   s1_m_reg;
    logic [RW-1:0]   s1_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s1_trunc_reg <= emit_trunc;
            s1_ovf_reg   <= ovf_reg;
            s1_q_reg     <= q_reg;
            s1_m_reg     <= m_reg;
            s1_r_reg     <= emit_r;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: q * m
    // ------------------------------------------------------------------
    logic            s2_trunc_reg, s2_ovf_reg;
    logic [PW-1:0]   s2_prod_reg;
    logic [RW-1:0]   s2_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_trunc_reg <= s1_trunc_reg;
            s2_ovf_reg   <= s1_ovf_reg;
            s2_prod_reg  <= PW'(s1_q_reg) * PW'(s1_m_reg);
            s2_r_reg     <= s1_r_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: add the remainder, saturate, undo the zigzag mapping
    // ------------------------------------------------------------------
    logic [SW-1:0]   sum;
    logic            sat;
    logic [VW-1:0]   value_next, value_reg;
    logic [1:0]      status_next, status_reg;

    always_comb
    begin
        // remainder may be negative when the divisor moved mid codeword
        sum = {2'b00, s2_prod_reg} + {{(SW - RW){s2_r_reg[RW-1]}}, s2_r_reg};
        sat = s2_ovf_reg || sum[SW-1] || (|sum[SW-2:VW]);
        if (s2_trunc_reg)
        begin
            value_next  = '0;
            status_next = gsd_pkg::STATUS_TRUNC;
        end
        else if (sat)
        begin
            value_next  = sum[0] ? {1'b1, {(VW - 1){1'b0}}} : {1'b0, {(VW - 1){1'b1}}};
            status_next = gsd_pkg::STATUS_OVF;
        end
        else
        begin
            value_next  = sum[0] ? ~sum[VW:1] : sum[VW:1];
            status_next = gsd_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s2_valid_reg)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_threshold: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, t_reg} + {1'b0, m_reg}) == ((DW + 1)'(1) << b_reg))
        else $error("threshold and divisor disagree with b");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the emit pipeline");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind) |=> (phase_reg == gsd_pkg::PH_IDLE && q_reg == '0 && !ovf_reg))
        else $error("end marker left codeword state behind");

    a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == gsd_pkg::STATUS_TRUNC) |-> (value == '0))
        else $error("truncated result carries a value");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == gsd_pkg::STATUS_OK || status == gsd_pkg::STATUS_TRUNC
                       || status == gsd_pkg::STATUS_OVF))
        else $error("undefined status code");

endmodule
